FILE: rtl/lr3d_pkg.sv
`default_nettype none

package lr3d_pkg;

   // Storage width of a coordinate; the active range is set by COORD_BITS on the top level.
   localparam int COORD_W = 6;
   localparam int COLOR_W = 8;
   // Error terms stay within about four times the coordinate range, signed.
   localparam int ERR_W = COORD_W + 3;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // One classified line, handed from the setup stage to the stepper.
   typedef struct packed {
      logic [2:0][COORD_W-1:0] start;
      logic [2:0][COORD_W-1:0] delta;
      logic [2:0]              neg;
      axis_type                major;
      logic [COLOR_W-1:0]      color;
   } job_type;

endpackage

`default_nettype wire

FILE: rtl/lr3d_setup.sv
`default_nettype none

module lr3d_setup
   import lr3d_pkg::*;
#(
   parameter int COORD_BITS = 6
) (
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  job_ready,
   output logic                       job_valid,
   output job_type                    job
);

   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);

   logic [2:0][COORD_W-1:0] s_pt;
   logic [2:0][COORD_W-1:0] e_pt;

   // Setup is pure logic; the queue behind it provides the register stage.
   assign req_tready = job_ready;
   assign job_valid  = req_tvalid;

   always_comb begin
      job = '0;
      for (int a = 0; a < 3; a++) begin
         s_pt[a] = req_tdata[a*COORD_W +: COORD_W] & COORD_MASK;
         e_pt[a] = req_tdata[(a+3)*COORD_W +: COORD_W] & COORD_MASK;
         job.start[a] = s_pt[a];
         job.neg[a]   = e_pt[a] < s_pt[a];
         job.delta[a] = job.neg[a] ? (s_pt[a] - e_pt[a]) : (e_pt[a] - s_pt[a]);
      end
      if (job.delta[0] >= job.delta[1] && job.delta[0] >= job.delta[2]) begin
         job.major = AXIS_X;
      end else if (job.delta[1] >= job.delta[2]) begin
         job.major = AXIS_Y;
      end else begin
         job.major = AXIS_Z;
      end
      job.color = req_tdata[6*COORD_W +: COLOR_W];
   end

endmodule

`default_nettype wire

FILE: rtl/lr3d_queue.sv
`default_nettype none

module lr3d_queue
   import lr3d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire job_type in_job,
   output logic         out_valid,
   input  wire logic    out_ready,
   output job_type      out_job
);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               push;
   logic               pop;

   assign in_ready  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lr3d_stepper.sv
`default_nettype none

module lr3d_stepper
   import lr3d_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_valid,
   output logic                       job_ready,
   input  wire job_type               job,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   logic [2:0][COORD_W-1:0]       pos_ff;
   logic [2:0][COORD_W-1:0]       pos_in;
   logic signed [ERR_W-1:0]       err_ff [3];
   logic signed [ERR_W-1:0]       err_in [3];
   logic [2:0][COORD_W-1:0]       delta_ff;
   logic [2:0]                    neg_ff;
   axis_type                      major_ff;
   logic [COLOR_W-1:0]            color_ff;
   logic [COORD_W-1:0]            left_ff;
   logic [COORD_W-1:0]            left_in;
   logic                          active_ff;
   logic                          active_in;
   logic                          out_valid_ff;
   logic [2:0][COORD_W-1:0]       out_pos_ff;
   logic [COLOR_W-1:0]            out_color_ff;
   logic                          out_last_ff;
   logic                          emit;
   logic                          load;
   logic [1:0]                    maj_idx;
   logic signed [ERR_W-1:0]       maj2;
   logic signed [ERR_W-1:0]       job_maj;
   logic [1:0]                    job_idx;

   assign emit      = active_ff && (!out_valid_ff || rsp_tready);
   assign load      = job_valid && (!active_ff || (emit && left_ff == '0));
   assign job_ready = load;

   assign maj_idx = major_ff;
   assign job_idx = job.major;
   assign maj2    = signed'({2'b00, delta_ff[maj_idx], 1'b0});
   assign job_maj = signed'({3'b000, job.delta[job_idx]});

   always_comb begin
      pos_in    = pos_ff;
      left_in   = left_ff;
      active_in = active_ff;
      for (int a = 0; a < 3; a++) begin
         err_in[a] = err_ff[a];
      end
      if (emit) begin
         if (left_ff == '0) begin
            active_in = 1'b0;
         end else begin
            left_in = left_ff - 1'b1;
            for (int a = 0; a < 3; a++) begin
               if (a == int'(maj_idx)) begin
                  pos_in[a] = neg_ff[a] ? pos_ff[a] - 1'b1 : pos_ff[a] + 1'b1;
               end else if (err_ff[a] > 0) begin
                  pos_in[a] = neg_ff[a] ? pos_ff[a] - 1'b1 : pos_ff[a] + 1'b1;
                  err_in[a] = err_ff[a] - maj2 + signed'({2'b00, delta_ff[a], 1'b0});
               end else begin
                  err_in[a] = err_ff[a] + signed'({2'b00, delta_ff[a], 1'b0});
               end
            end
         end
      end
      if (load) begin
         active_in = 1'b1;
         pos_in    = job.start;
         left_in   = job.delta[job_idx];
         for (int a = 0; a < 3; a++) begin
            err_in[a] = signed'({2'b00, job.delta[a], 1'b0}) - job_maj;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      left_ff <= left_in;
      for (int a = 0; a < 3; a++) begin
         err_ff[a] <= err_in[a];
      end
      if (load) begin
         delta_ff <= job.delta;
         neg_ff   <= job.neg;
         major_ff <= job.major;
         color_ff <= job.color;
      end
      if (emit) begin
         out_pos_ff   <= pos_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= left_ff == '0;
      end
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_color_ff, out_pos_ff});

endmodule

`default_nettype wire

FILE: rtl/line_rasterizer_3d.sv
// Path: each line goes through the line queue, the stepper registers and the output register.
// Throughput: one point per cycle unless the consumer stalls; a line gives its dominant length
// plus one points (1 to 64 at six bits); lines follow without a gap, paced by the stepper.
// Reset: synchronous, active high; it empties the line queue, stops the stepper and
// drops any point held in the output register.
`default_nettype none

module line_rasterizer_3d
   import lr3d_pkg::*;
#(
   parameter int COORD_BITS = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Line requests.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0: x_start[6], y_start[6], z_start[6], x_end[6], y_end[6],
   // z_end[6], color[8], then four zero bits.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Voxel points.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Fields from bit 0: point_x[6], point_y[6], point_z[6], point_color[8],
   // then six zero bits.
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // Marks the final point of a line.
   output logic                       rsp_tlast
);

   // The setup stage masks the coordinates to COORD_BITS, measures the distance and
   // direction on each axis, and picks the driving axis (ties go to x, then y).
   // Classified lines wait in a two-entry queue, so a new request can be taken while
   // the stepper is still drawing the previous line.
   logic    setup_valid;
   logic    setup_ready;
   job_type setup_job;
   logic    queue_valid;
   logic    queue_ready;
   job_type queue_job;

   lr3d_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .job_ready  (setup_ready),
      .job_valid  (setup_valid),
      .job        (setup_job)
   );

   lr3d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_valid),
      .in_ready  (setup_ready),
      .in_job    (setup_job),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_job   (queue_job)
   );

   // The stepper walks the driving axis one voxel per cycle while the output is not stalled,
   // and keeps one error term per minor axis; a minor axis moves when its error is above zero.
   // Each point goes through an output register that holds it while the consumer stalls.
   lr3d_stepper u_stepper (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (queue_valid),
      .job_ready  (queue_ready),
      .job        (queue_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
